/* sv/assert_macros.svh */
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on the same edge
`define ASSERT_IMPL(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("lbl");
// assert that a implies b on the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("lbl");
`endif

/* sv/lfo_pkg.sv */
// ----------------------------------------------------------------------------
// LFO package
// Types, codes and constants shared by the oscillator modules.
// ----------------------------------------------------------------------------
package lfo_pkg;
  localparam int TablePointsDef = 129;
  localparam int NumTablesDef   = 5;

  localparam logic [15:0] MAX_INC      = 16'h28F6;
  localparam logic [15:0] INTERP_BELOW = 16'h0200;
  localparam logic [16:0] SLEW_STEP    = 17'h001C2;
  localparam logic [4:0]  SEL_MAX      = 5'h1E;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_RESTART = 3'd1;
  localparam logic [2:0] OP_ACT     = 3'd2;
  localparam logic [2:0] OP_TWRITE  = 3'd3;
  localparam logic [2:0] OP_SEED    = 3'd4;

  localparam logic [2:0] REG_WSEL  = 3'd0;
  localparam logic [2:0] REG_BASE  = 3'd1;
  localparam logic [2:0] REG_DELAY = 3'd2;
  localparam logic [2:0] REG_FADE  = 3'd3;
  localparam logic [2:0] REG_START = 3'd4;

  localparam logic [4:0] SEL_SINE   = 5'h00;
  localparam logic [4:0] SEL_SQUARE = 5'h02;
  localparam logic [4:0] SEL_TRI    = 5'h06;
  localparam logic [4:0] SEL_RTRI   = 5'h08;
  localparam logic [4:0] SEL_RHOLD  = 5'h0A;
  localparam logic [4:0] SEL_SLEW   = 5'h0C;
  localparam logic [4:0] SEL_T1     = 5'h10;
  localparam logic [4:0] SEL_T2     = 5'h12;
  localparam logic [4:0] SEL_T3     = 5'h14;
  localparam logic [4:0] SEL_T4     = 5'h16;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [15:0] rate_mod;
    logic [7:0]         catchup_steps;
    logic [2:0]         table_select;
    logic [7:0]         table_point;
    logic [15:0]        write_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [15:0]        fade_level;
    logic               status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // form increment and step count
    logic step;      // one ramp and phase step
    logic rd_first;  // issue first table read
    logic rd_second; // issue second table read
    logic finish;    // form sample
  } lfo_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_step;
    logic is_tick;
    logic inc_zero;
    logic need_table;
    logic need_second;
  } lfo_sts_t;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [15:0] triangle(input logic [15:0] p);
    logic [15:0] d;
    d = {p[14:0], 1'b0};
    if (p[15] ^ d[15]) d = ~d;
    return d;
  endfunction
endpackage

/* sv/lfo_phase_ramp_waveform_core.sv */
// A tick goes through the load, step, table read and finish states, the reads
// only as needed; other items go from load to finish. One ramp and phase step
// per cycle in the datapath. The core takes one item at a time.
// Reset: synchronous active-low rst_n clears controller state and the config
// and oscillator registers; table contents are undefined until written.
// ----------------------------------------------------------------------------
// LFO phase ramp waveform core
// Top level joining controller and datapath.
// ----------------------------------------------------------------------------
module lfo_phase_ramp_waveform_core #(
  parameter int TABLE_POINTS = lfo_pkg::TablePointsDef,
  parameter int NUM_TABLES   = lfo_pkg::NumTablesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lfo_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lfo_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import lfo_pkg::*;
`include "assert_macros.svh"

  lfo_cmd_t cmd;
  lfo_sts_t sts;
  logic     accept;

  assign accept = in_valid && in_ready;

  lfo_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  lfo_datapath #(.TABLE_POINTS(TABLE_POINTS), .NUM_TABLES(NUM_TABLES)) u_dp (
    .clk, .rst_n, .accept, .in_data, .cfg_index, .cfg_data, .cfg_we, .cmd, .sts,
    .out_data
  );

  `ASSERT_IMPL(a_cmd_onehot, clk, rst_n, 1'b1, $onehot0(cmd))
  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, (cmd != '0), !in_ready)
  `ASSERT_NEXT(a_fin_valid, clk, rst_n, cmd.finish, out_valid)
endmodule

/* sv/lfo_ctrl.sv */
// ----------------------------------------------------------------------------
// LFO controller
// Sequences load, step iterations, table reads and sample formation.
// ----------------------------------------------------------------------------
module lfo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lfo_pkg::lfo_sts_t sts,
  output lfo_pkg::lfo_cmd_t cmd
);
  import lfo_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_RD1  = 3'd3;
  localparam logic [2:0] S_RD2  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       accept;

  assign in_ready  = (state_r == S_IDLE) && (!ovalid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        state_nxt = sts.is_tick ? S_STEP : S_FIN;
      end
      S_STEP: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          if (sts.inc_zero) state_nxt = S_FIN;
          else if (sts.need_table) state_nxt = S_RD1;
          else state_nxt = S_FIN;
        end
      end
      S_RD1: begin
        cmd.rd_first = 1'b1;
        state_nxt = sts.need_second ? S_RD2 : S_FIN;
      end
      S_RD2: begin
        cmd.rd_second = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

/* sv/lfo_datapath.sv */
// ----------------------------------------------------------------------------
// LFO datapath
// Oscillator state, ramp and phase step unit, table memory, sample former.
// ----------------------------------------------------------------------------
module lfo_datapath #(
  parameter int TABLE_POINTS = lfo_pkg::TablePointsDef,
  parameter int NUM_TABLES   = lfo_pkg::NumTablesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  lfo_pkg::in_item_t  in_data,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               cfg_we,
  input  lfo_pkg::lfo_cmd_t  cmd,
  output lfo_pkg::lfo_sts_t  sts,
  output lfo_pkg::out_item_t out_data
);
  import lfo_pkg::*;

  localparam int Depth = TABLE_POINTS * NUM_TABLES;
  localparam int AW    = $clog2(Depth);

  logic [4:0]  wsel_r;
  logic [15:0] base_r, delay_rate_r, fade_rate_r;
  logic [7:0]  start_r;
  in_item_t    item_r;
  logic [15:0] phase_r, delay_r, fade_r, seed_r, target_r, last_r;
  logic        status_r;
  logic [15:0] inc_r;
  logic [8:0]  cnt_r;
  logic        fade_on_r;
  logic [15:0] mem [Depth];
  logic [15:0] rdata_r, first_r;
  logic [15:0] base_sum;
  logic        sel_bad;
  logic [2:0]  tab_num;
  logic        tab_ok;
  logic [6:0]  idx;
  logic [AW-1:0] waddr, raddr;
  logic        wok;

  assign base_sum = base_r + item_r.rate_mod;
  assign sel_bad  = wsel_r[0] || (wsel_r > SEL_MAX);

  always_comb begin
    unique case (wsel_r)
      SEL_SINE: tab_num = 3'd0;
      SEL_T1:   tab_num = 3'd1;
      SEL_T2:   tab_num = 3'd2;
      SEL_T3:   tab_num = 3'd3;
      SEL_T4:   tab_num = 3'd4;
      default:  tab_num = 3'd7;
    endcase
  end
  assign tab_ok = (32'(tab_num) < NUM_TABLES);
  assign idx    = phase_r[15:9];

  assign sts.last_step   = (cnt_r == 9'd1);
  assign sts.is_tick     = (item_r.opcode == OP_TICK);
  assign sts.inc_zero    = (inc_r == 16'd0);
  assign sts.need_table  = !sel_bad && (tab_num != 3'd7);
  assign sts.need_second = (inc_r < INTERP_BELOW);

  assign wok   = (32'(in_data.table_select) < NUM_TABLES) &&
                 (32'(in_data.table_point) < TABLE_POINTS);
  assign waddr = AW'(32'(in_data.table_select) * TABLE_POINTS + 32'(in_data.table_point));
  assign raddr = AW'(32'(tab_num) * TABLE_POINTS + 32'(idx) + (cmd.rd_second ? 1 : 0));

  always_ff @(posedge clk) begin
    if (accept && in_data.opcode == OP_TWRITE && wok) mem[waddr] <= in_data.write_value;
    if (cmd.rd_first || cmd.rd_second) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
  end

  // table sample from registered reads
  logic [15:0] samp_tab;
  logic [15:0] diff;
  logic signed [16:0] delta;
  logic signed [33:0] prod;
  logic [15:0] mult;
  logic [15:0] rd2;
  always_comb begin
    rd2   = (tab_ok && (32'(idx) + 1 < TABLE_POINTS)) ? rdata_r : 16'd0;
    mult  = swap16({1'b0, phase_r[15:1]});
    diff  = rd2 - first_r;
    delta = {diff[15], diff};
    prod  = delta * $signed({1'b0, mult});
    // truncating division toward zero by 65536
    if (prod < 0) prod = prod + 34'sd65535;
    samp_tab = sts.need_second ? first_r + prod[31:16] : first_r;
  end

  logic [15:0] samp, tri_v;
  logic [16:0] cur, tgt, c;
  always_comb begin
    cur = {last_r[15], last_r};
    tgt = {target_r[15], target_r};
    if ($signed(tgt) >= $signed(cur)) begin
      c = cur + SLEW_STEP;
      if ($signed(c) > $signed(tgt)) c = tgt;
    end else begin
      c = cur - SLEW_STEP;
      if ($signed(c) < $signed(tgt)) c = tgt;
    end
    tri_v = triangle(phase_r);
    unique case (wsel_r)
      SEL_SQUARE: samp = phase_r[15] ? 16'h8000 : 16'h7FFF;
      SEL_TRI:    samp = tri_v;
      SEL_RTRI:   samp = tri_v[15] ? tri_v - 16'h7FFF : tri_v;
      SEL_RHOLD:  samp = target_r;
      SEL_SLEW:   samp = c[15:0];
      SEL_SINE, SEL_T1, SEL_T2, SEL_T3, SEL_T4: samp = samp_tab;
      default:    samp = phase_r;
    endcase
  end

  logic [15:0] dsum, fsum, psum;
  logic        p_ovf;
  logic        d_carry;
  assign dsum    = delay_r + delay_rate_r;
  assign fsum    = fade_r + fade_rate_r;
  assign psum    = phase_r + inc_r;
  assign p_ovf   = (~(phase_r[15] ^ inc_r[15])) & (phase_r[15] ^ psum[15]);
  // the step that carries the delay ramp also takes the first fade step
  assign d_carry = !fade_on_r && (dsum < delay_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsel_r <= '0; base_r <= '0; delay_rate_r <= '0; fade_rate_r <= '0; start_r <= '0;
      phase_r <= '0; delay_r <= '0; fade_r <= '0; seed_r <= '0; target_r <= '0;
      last_r <= '0; status_r <= 1'b0; inc_r <= '0; cnt_r <= '0; fade_on_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WSEL:  wsel_r       <= cfg_data[4:0];
          REG_BASE:  base_r       <= cfg_data;
          REG_DELAY: delay_rate_r <= cfg_data;
          REG_FADE:  fade_rate_r  <= cfg_data;
          REG_START: start_r      <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        status_r  <= 1'b0;
        cnt_r     <= 9'(item_r.catchup_steps) + 9'd1;
        fade_on_r <= (fade_r != 16'd0);
        if (base_sum[15] || base_sum == 16'd0) inc_r <= 16'd0;
        else if (base_sum > MAX_INC) inc_r <= MAX_INC;
        else inc_r <= base_sum;
        unique case (item_r.opcode)
          OP_RESTART: begin
            phase_r  <= {start_r, 8'd0};
            delay_r  <= delay_rate_r;
            fade_r   <= (delay_rate_r == 16'hFFFF) ? fade_rate_r : 16'd0;
            last_r   <= '0;
            target_r <= '0;
          end
          OP_ACT:  if (delay_rate_r == 16'd0) fade_r <= 16'd1;
          OP_SEED: seed_r <= item_r.write_value;
          default: ;
        endcase
      end
      if (cmd.step) begin
        cnt_r <= cnt_r - 9'd1;
        if (!fade_on_r) begin
          delay_r <= dsum;
          if (d_carry) fade_on_r <= 1'b1;
        end
        if ((fade_on_r || d_carry) && (fade_r != 16'hFFFF || fade_rate_r == 16'd0)) begin
          if (fsum < fade_r) fade_r <= 16'hFFFF;
          else fade_r <= fsum;
        end
        if (inc_r != 16'd0) begin
          phase_r <= psum;
          if (p_ovf) begin
            seed_r   <= swap16(seed_r + psum);
            target_r <= swap16(seed_r + psum);
          end
        end
      end
      if (cmd.finish && sts.is_tick && !sts.inc_zero) begin
        if (sel_bad) status_r <= 1'b1;
        else last_r <= samp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_first) first_r <= tab_ok ? mem[raddr] : 16'd0;
  end

  assign out_data.sample_out = last_r;
  assign out_data.fade_level = fade_r;
  assign out_data.status     = status_r;
endmodule
